// File: rtl/core/two_link_planar_inverse_kinematics_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-link inverse kinematics block
// Shared concurrent assertion forms on the block clock and reset.
// ---------------------------------------------------------------------------
`ifndef TWO_LINK_PLANAR_INVERSE_KINEMATICS_TOP_DEFINES_SVH
`define TWO_LINK_PLANAR_INVERSE_KINEMATICS_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TLIK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlik assertion failed");

// Next-cycle implication, checked outside reset.
`define TLIK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlik assertion failed");

`endif

// File: rtl/core/tlik_pkg.sv
// ---------------------------------------------------------------------------
// Two-link inverse kinematics package
// Types, angle constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package tlik_pkg;

  // Configuration register indexes.
  localparam logic CFG_UPPER = 1'b0;
  localparam logic CFG_LOWER = 1'b1;

  // Square root steps (one result bit each) and normalizing shift steps.
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned NORM_STEPS = 5;

  // Angles in Q16 degrees.
  localparam logic [22:0]        DEG90_Q16  = 23'd5898240;
  localparam logic signed [25:0] DEG180_Q16 = 26'sd11796480;

  typedef logic signed [33:0] cval_t;
  typedef logic signed [24:0] zval_t;

  // One CORDIC lane: vector, accumulated angle and a both-inputs-zero mark.
  typedef struct packed {
    logic  zero;
    cval_t x;
    cval_t y;
    zval_t z;
  } lane_t;

  // Per-target flags that travel with the data.
  typedef struct packed {
    logic unr;
    logic xneg;
    logic yneg;
    logic xzero;
    logic cneg;
    logic pneg;
  } side_t;

  // Operands carried alongside the square root.
  typedef struct packed {
    side_t       side;
    logic [31:0] cm;
    logic [31:0] pm;
    logic [15:0] ax;
    logic [15:0] ay;
  } pay_t;

  // Rounded arctangent of 2^-i in Q16 degrees.
  function automatic zval_t atan_deg(input int unsigned idx);
    zval_t r;
    case (idx)
      0:       r = 25'sd2949120;
      1:       r = 25'sd1740967;
      2:       r = 25'sd919879;
      3:       r = 25'sd466945;
      4:       r = 25'sd234379;
      5:       r = 25'sd117304;
      6:       r = 25'sd58666;
      7:       r = 25'sd29335;
      8:       r = 25'sd14668;
      9:       r = 25'sd7334;
      10:      r = 25'sd3667;
      11:      r = 25'sd1833;
      12:      r = 25'sd917;
      13:      r = 25'sd458;
      14:      r = 25'sd229;
      15:      r = 25'sd115;
      16:      r = 25'sd57;
      17:      r = 25'sd29;
      18:      r = 25'sd14;
      19:      r = 25'sd7;
      20:      r = 25'sd4;
      21:      r = 25'sd2;
      22:      r = 25'sd1;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/two_link_planar_inverse_kinematics_top.sv
// ---------------------------------------------------------------------------
// Two-link planar arm inverse kinematics
// Target point in, shoulder and elbow angles out, fully pipelined.
// ---------------------------------------------------------------------------
// The block accepts one target per clock until a stall at the output has
// filled the pipeline. The pipeline holds the square root (32 stages, one
// result bit each), the six normalizing stages and the three CORDIC lanes
// that run side by side with one iteration per stage. Every stage holds its
// own valid bit and moves when the stage after it is empty or moving, so a
// stall at the output fills bubbles before it stops the input. Link lengths
// are to be written by the user through the configuration port only while
// the block is idle; the block itself does not enforce this.

module two_link_planar_inverse_kinematics_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [14:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  target_x_i,
  input  logic signed [15:0]  target_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  shoulder_angle_o,
  output logic [14:0]         elbow_angle_o,
  output logic                unreachable_o
);

  `include "two_link_planar_inverse_kinematics_top_defines.svh"

  localparam int unsigned ST_ROOT = 4;
  localparam int unsigned ST_NRM  = ST_ROOT + tlik_pkg::SQRT_STEPS;
  localparam int unsigned ST_NL   = ST_NRM + 1;
  localparam int unsigned ST_COR  = ST_NL + tlik_pkg::NORM_STEPS;
  localparam int unsigned ST_FIN  = ST_COR + CORDIC_STEPS;
  localparam int unsigned ST_OUT  = ST_FIN + 1;
  localparam int unsigned NST     = ST_OUT + 1;

  // Configuration registers.
  logic [14:0] upper_q, lower_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 15'd256;
      lower_q <= 15'd256;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tlik_pkg::CFG_UPPER) begin
        upper_q <= cfg_data_i;
      end
      if (cfg_index_i == tlik_pkg::CFG_LOWER) begin
        lower_q <= cfg_data_i;
      end
    end
  end

  // Stage valid bits and the enable chain: a stage loads when it is empty
  // or its successor loads.
  logic [NST-1:0] vld_q;
  logic [NST:0]   en;

  assign en[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NST-1];

  // Carried operands and flags, one entry per stage up to the final angle stage.
  tlik_pkg::pay_t car_q [ST_FIN+1];

  for (genvar k = 2; k <= ST_FIN; k++) begin : g_car
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        car_q[k] <= car_q[k-1];
      end
    end
  end

  // Stage 0: magnitudes and squares.
  logic [15:0] ax_d, ay_d;
  logic [31:0] xx_q, yy_q, aa_q, bb_q, ab_q;

  assign ax_d = target_x_i[15] ? 16'(-target_x_i) : 16'(target_x_i);
  assign ay_d = target_y_i[15] ? 16'(-target_y_i) : 16'(target_y_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      xx_q <= 32'(ax_d) * 32'(ax_d);
      yy_q <= 32'(ay_d) * 32'(ay_d);
      aa_q <= 32'(upper_q) * 32'(upper_q);
      bb_q <= 32'(lower_q) * 32'(lower_q);
      ab_q <= 32'(upper_q) * 32'(lower_q);
      car_q[0].side.xneg  <= target_x_i[15];
      car_q[0].side.yneg  <= target_y_i[15];
      car_q[0].side.xzero <= (target_x_i == 16'sd0);
      car_q[0].side.unr   <= 1'b0;
      car_q[0].side.cneg  <= 1'b0;
      car_q[0].side.pneg  <= 1'b0;
      car_q[0].cm         <= '0;
      car_q[0].pm         <= '0;
      car_q[0].ax         <= ax_d;
      car_q[0].ay         <= ay_d;
    end
  end

  // Stage 1: law of cosines terms and the reach test.
  logic [31:0]        l2_d, d_d;
  logic signed [33:0] c_d, p_d, ds_d;
  logic [31:0]        d_q;

  assign l2_d = xx_q + yy_q;
  assign d_d  = {ab_q[30:0], 1'b0};
  assign ds_d = $signed({2'b00, d_d});
  assign c_d  = $signed({2'b00, aa_q}) + $signed({2'b00, bb_q}) - $signed({2'b00, l2_d});
  assign p_d  = $signed({2'b00, aa_q}) + $signed({2'b00, l2_d}) - $signed({2'b00, bb_q});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d_q                 <= d_d;
      car_q[1].side.xneg  <= car_q[0].side.xneg;
      car_q[1].side.yneg  <= car_q[0].side.yneg;
      car_q[1].side.xzero <= car_q[0].side.xzero;
      car_q[1].side.unr   <= (l2_d == 32'd0) || (d_d == 32'd0) || (c_d > ds_d) ||
                             (c_d < -ds_d);
      car_q[1].side.cneg  <= c_d[33];
      car_q[1].side.pneg  <= p_d[33];
      car_q[1].cm         <= c_d[33] ? 32'(-c_d) : 32'(c_d);
      car_q[1].pm         <= p_d[33] ? 32'(-p_d) : 32'(p_d);
      car_q[1].ax         <= car_q[0].ax;
      car_q[1].ay         <= car_q[0].ay;
    end
  end

  // Stage 2: squares of D and C.
  logic [63:0] dd_q, cc_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dd_q <= 64'(d_q) * 64'(d_q);
      cc_q <= 64'(car_q[1].cm) * 64'(car_q[1].cm);
    end
  end

  // Stage 3 loads the radicand; the root stages follow, one bit each.
  logic [62:0] sq_rem_q [tlik_pkg::SQRT_STEPS+1];
  logic [62:0] sq_res_q [tlik_pkg::SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sq_rem_q[0] <= 63'(dd_q - cc_q);
      sq_res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < tlik_pkg::SQRT_STEPS; k++) begin : g_root
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
    logic [62:0] t_d;
    assign t_d = sq_res_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (en[ST_ROOT+k]) begin
        if (sq_rem_q[k] >= t_d) begin
          sq_rem_q[k+1] <= sq_rem_q[k] - t_d;
          sq_res_q[k+1] <= (sq_res_q[k] >> 1) + BIT;
        end else begin
          sq_rem_q[k+1] <= sq_rem_q[k];
          sq_res_q[k+1] <= sq_res_q[k] >> 1;
        end
      end
    end
  end

  // Normalize, right side: bring each lane below 2^30.
  tlik_pkg::lane_t nr_q [3];
  logic [31:0]     la_d [3];
  logic [31:0]     lb_d [3];

  assign la_d[0] = car_q[ST_NRM-1].cm;
  assign lb_d[0] = sq_res_q[tlik_pkg::SQRT_STEPS][31:0];
  assign la_d[1] = car_q[ST_NRM-1].pm;
  assign lb_d[1] = sq_res_q[tlik_pkg::SQRT_STEPS][31:0];
  assign la_d[2] = 32'(car_q[ST_NRM-1].ax);
  assign lb_d[2] = 32'(car_q[ST_NRM-1].ay);

  for (genvar j = 0; j < 3; j++) begin : g_nrm
    logic [31:0] o_d;
    logic [1:0]  sh_d;
    assign o_d  = la_d[j] | lb_d[j];
    assign sh_d = o_d[31] ? 2'd2 : (o_d[30] ? 2'd1 : 2'd0);
    always_ff @(posedge clk_i) begin
      if (en[ST_NRM]) begin
        nr_q[j].zero <= (o_d == 32'd0);
        nr_q[j].x    <= $signed({2'b00, la_d[j] >> sh_d});
        nr_q[j].y    <= $signed({2'b00, lb_d[j] >> sh_d});
        nr_q[j].z    <= '0;
      end
    end
  end

  // Normalize, left side: shifts of 16, 8, 4, 2 and 1 toward [2^29, 2^30).
  tlik_pkg::lane_t nl_q [tlik_pkg::NORM_STEPS][3];

  for (genvar m = 0; m < tlik_pkg::NORM_STEPS; m++) begin : g_nl
    localparam int unsigned SH = 16 >> m;
    for (genvar j = 0; j < 3; j++) begin : g_lane
      tlik_pkg::lane_t src_d;
      tlik_pkg::lane_t dst_d;
      tlik_pkg::cval_t o_d;
      if (m == 0) begin : g_first
        assign src_d = nr_q[j];
      end else begin : g_next
        assign src_d = nl_q[m-1][j];
      end
      assign o_d = src_d.x | src_d.y;
      always_comb begin
        dst_d = src_d;
        if ((o_d >>> (30 - SH)) == 34'sd0) begin
          dst_d.x = src_d.x <<< SH;
          dst_d.y = src_d.y <<< SH;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en[ST_NL+m]) begin
          nl_q[m][j] <= dst_d;
        end
      end
    end
  end

  // CORDIC vectoring, one iteration per stage on all three lanes.
  tlik_pkg::lane_t cd_q [CORDIC_STEPS][3];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    localparam tlik_pkg::zval_t AT = tlik_pkg::atan_deg(i);
    for (genvar j = 0; j < 3; j++) begin : g_lane
      tlik_pkg::lane_t src_d;
      tlik_pkg::cval_t dx_d, dy_d;
      if (i == 0) begin : g_first
        assign src_d = nl_q[tlik_pkg::NORM_STEPS-1][j];
      end else begin : g_next
        assign src_d = cd_q[i-1][j];
      end
      assign dx_d = src_d.y >>> i;
      assign dy_d = src_d.x >>> i;
      always_ff @(posedge clk_i) begin
        if (en[ST_COR+i]) begin
          cd_q[i][j].zero <= src_d.zero;
          if (!src_d.y[33]) begin
            cd_q[i][j].x <= src_d.x + dx_d;
            cd_q[i][j].y <= src_d.y - dy_d;
            cd_q[i][j].z <= src_d.z + AT;
          end else begin
            cd_q[i][j].x <= src_d.x - dx_d;
            cd_q[i][j].y <= src_d.y + dy_d;
            cd_q[i][j].z <= src_d.z - AT;
          end
        end
      end
    end
  end

  // Clamp each angle to [0, 90] degrees and fold in the quadrant.
  logic [22:0]        t_d [3];
  logic signed [25:0] ts_d [3];
  tlik_pkg::side_t    fs_d;
  logic signed [25:0] elb_q, tri_q, base_q;

  assign fs_d = car_q[ST_FIN-1].side;

  for (genvar j = 0; j < 3; j++) begin : g_clamp
    tlik_pkg::zval_t z_d;
    assign z_d = cd_q[CORDIC_STEPS-1][j].z;
    always_comb begin
      if (cd_q[CORDIC_STEPS-1][j].zero || z_d[24]) begin
        t_d[j] = '0;
      end else if (z_d > $signed({2'b00, tlik_pkg::DEG90_Q16})) begin
        t_d[j] = tlik_pkg::DEG90_Q16;
      end else begin
        t_d[j] = z_d[22:0];
      end
    end
    assign ts_d[j] = $signed({3'b000, t_d[j]});
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_FIN]) begin
      elb_q <= (fs_d.cneg ? tlik_pkg::DEG180_Q16 - ts_d[0] : ts_d[0]) + tlik_pkg::DEG180_Q16;
      tri_q <= fs_d.pneg ? tlik_pkg::DEG180_Q16 - ts_d[1] : ts_d[1];
      if (fs_d.xzero) begin
        base_q <= fs_d.yneg ? -$signed({3'b000, tlik_pkg::DEG90_Q16})
                            : $signed({3'b000, tlik_pkg::DEG90_Q16});
      end else begin
        base_q <= (fs_d.xneg ^ fs_d.yneg) ? -ts_d[2] : ts_d[2];
      end
    end
  end

  // Output register: sum, round half up to Q10.6, zero when unreachable.
  logic signed [25:0] shs_d, shr_d, elr_d;
  logic signed [15:0] shoulder_q;
  logic [14:0]        elbow_q;
  logic               unr_q;

  assign shs_d = base_q + tri_q;
  assign shr_d = (shs_d + 26'sd512) >>> 10;
  assign elr_d = (elb_q + 26'sd512) >>> 10;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      unr_q <= car_q[ST_FIN].side.unr;
      if (car_q[ST_FIN].side.unr) begin
        shoulder_q <= '0;
        elbow_q    <= '0;
      end else begin
        shoulder_q <= shr_d[15:0];
        elbow_q    <= elr_d[14:0];
      end
    end
  end

  assign shoulder_angle_o = shoulder_q;
  assign elbow_angle_o    = elbow_q;
  assign unreachable_o    = unr_q;

  // Checks on the datapath results and the stall chain.
  `TLIK_ASSERT_NOW(a_unr_zero, out_valid_o && unreachable_o,
                   shoulder_angle_o == 16'sd0 && elbow_angle_o == 15'd0)
  `TLIK_ASSERT_NOW(a_elbow_range, out_valid_o && !unreachable_o,
                   elbow_angle_o >= 15'd11520 && elbow_angle_o <= 15'd23040)
  `TLIK_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i)
  `TLIK_ASSERT_NEXT(a_drain, out_valid_o && out_ready_i && !vld_q[NST-2], !out_valid_o)

endmodule

// File: verif/two_link_planar_inverse_kinematics_top_tb.sv
// ---------------------------------------------------------------------------
// Two-link planar inverse kinematics testbench
// Drives targets under several link length settings with random gaps and
// output stalls. A scoreboard predicts each joint angle pair and compares it
// with the block's results in order.
// ---------------------------------------------------------------------------
module two_link_planar_inverse_kinematics_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam longint      Q16_DEG90    = 64'sd5898240;
  localparam longint      Q16_DEG180   = 64'sd11796480;

  typedef struct {
    logic signed [15:0] shoulder;
    logic [14:0]        elbow;
    logic               unr;
  } angles_t;

  // Predicts joint angles for each accepted target and checks results in order.
  class ik_scoreboard;
    angles_t      angles_q[$];
    longint       upper_len = 256;
    longint       lower_len = 256;
    int           n_errors  = 0;
    int           n_checked = 0;
    int           n_unreach = 0;
    longint       atan_q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                   58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                   229, 115};

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // First quadrant arctangent of b over a, in Q16 degrees.
    function longint quad_angle(longint unsigned a, longint unsigned b);
      longint vx, vy, z, dx, dy;
      z = 0;
      if (a == 0 && b == 0) return 0;
      while (a >= (64'd1 << 30) || b >= (64'd1 << 30)) begin
        a = a >> 1;
        b = b >> 1;
      end
      while (a < (64'd1 << 29) && b < (64'd1 << 29)) begin
        a = a << 1;
        b = b << 1;
      end
      vx = a;
      vy = b;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx += dx;
          vy -= dy;
          z  += atan_q16[i];
        end else begin
          vx -= dx;
          vy += dy;
          z  -= atan_q16[i];
        end
      end
      if (z < 0) z = 0;
      if (z > Q16_DEG90) z = Q16_DEG90;
      return z;
    endfunction

    // Angle in the upper half plane; a negative cosine side reflects it.
    function longint half_angle(longint c, longint unsigned s);
      if (c >= 0) return quad_angle(c, s);
      return Q16_DEG180 - quad_angle(-c, s);
    endfunction

    function void set_length(logic idx, longint val);
      if (idx == tlik_pkg::CFG_UPPER) upper_len = val;
      if (idx == tlik_pkg::CFG_LOWER) lower_len = val;
    endfunction

    function void note_target(logic signed [15:0] tx, logic signed [15:0] ty);
      longint  x, y, a, b, l2, d, c, p, base, tri_ang, elb, sh;
      longint unsigned s;
      angles_t e;
      x = tx;
      y = ty;
      a = upper_len;
      b = lower_len;
      l2 = x * x + y * y;
      d  = 2 * a * b;
      c  = a * a + b * b - l2;
      if (l2 == 0 || d == 0 || c > d || c < -d) begin
        e.shoulder = '0;
        e.elbow    = '0;
        e.unr      = 1'b1;
      end else begin
        s       = int_sqrt(longint'(d * d) - longint'(c * c));
        p       = a * a + l2 - b * b;
        elb     = half_angle(c, s) + Q16_DEG180;
        tri_ang = half_angle(p, s);
        if (x == 0) begin
          base = (y > 0) ? Q16_DEG90 : -Q16_DEG90;
        end else begin
          base = quad_angle(x < 0 ? -x : x, y < 0 ? -y : y);
          if ((x < 0) != (y < 0)) base = -base;
        end
        sh = base + tri_ang;
        sh = (sh + 512) >>> 10;
        elb = (elb + 512) >>> 10;
        e.shoulder = sh[15:0];
        e.elbow    = elb[14:0];
        e.unr      = 1'b0;
      end
      angles_q.push_back(e);
    endfunction

    function void check_result(logic signed [15:0] sh, logic [14:0] el, logic unr);
      angles_t e;
      if (angles_q.size() == 0) begin
        $display("%0t: unexpected result shoulder=%0d elbow=%0d unreachable=%0b",
                 $time, sh, el, unr);
        n_errors++;
        return;
      end
      e = angles_q.pop_front();
      n_checked++;
      if (e.unr) n_unreach++;
      if (sh !== e.shoulder) begin
        $display("%0t: shoulder expected %0d actual %0d", $time, e.shoulder, sh);
        n_errors++;
      end
      if (el !== e.elbow) begin
        $display("%0t: elbow expected %0d actual %0d", $time, e.elbow, el);
        n_errors++;
      end
      if (unr !== e.unr) begin
        $display("%0t: unreachable expected %0b actual %0b", $time, e.unr, unr);
        n_errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_index_i = '0;
  logic [14:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] target_x_i = '0;
  logic signed [15:0] target_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] shoulder_angle_o;
  logic [14:0]        elbow_angle_o;
  logic               unreachable_o;

  ik_scoreboard sb = new();
  int  n_sent = 0;
  bit  tx_burst = 0;
  bit  rx_burst = 0;
  longint n_cycles = 0;

  two_link_planar_inverse_kinematics_top #(.CORDIC_STEPS(CORDIC_STEPS)) i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", n_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off early in the longest-link
  // phase, where enough targets remain to fill the whole pipeline.
  initial begin
    int  gap;
    bit  held;
    held = 0;
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 15);
      if (!held && sb.n_checked == 152) begin
        gap  = 2000;
        held = 1;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(shoulder_angle_o, elbow_angle_o, unreachable_o);
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
    end
  end

  // Offer one target transaction after a random gap.
  task automatic send_target(logic signed [15:0] x, logic signed [15:0] y);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    target_x_i = x;
    target_y_i = y;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_target(x, y);
    n_sent++;
    if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
  endtask

  // Wait until every expected result has arrived, then let the pipeline drain.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.angles_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(logic idx, logic [14:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_length(idx, val);
  endtask

  // Random targets: mostly within the square bounded by the arm's reach, some anywhere.
  task automatic random_targets(int count);
    longint r, x, y;
    for (int i = 0; i < count; i++) begin
      r = sb.upper_len + sb.lower_len;
      if ($urandom_range(0, 9) < 7 && r < 32768) begin
        x = longint'($urandom_range(0, 2 * r)) - r;
        y = longint'($urandom_range(0, 2 * r)) - r;
      end else begin
        x = $signed(16'($urandom));
        y = $signed(16'($urandom));
      end
      send_target(16'(x), 16'(y));
    end
  endtask

  initial begin
    logic [14:0] la, lb;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed targets with both links at one unit.
    send_target(16'sd0, 16'sd0);
    send_target(16'sd0, 16'sd256);
    send_target(16'sd0, -16'sd256);
    send_target(16'sd0, 16'sd1);
    send_target(16'sd1, 16'sd0);
    send_target(-16'sd1, -16'sd1);
    send_target(16'sd512, 16'sd0);
    send_target(16'sd100, 16'sd0);
    send_target(16'sd256, 16'sd256);
    send_target(-16'sd256, 16'sd256);
    send_target(16'sd256, -16'sd256);
    send_target(-16'sd300, -16'sd100);
    send_target(16'sd32767, 16'sd32767);
    send_target(-16'sd32768, -16'sd32768);
    send_target(-16'sd32768, 16'sd0);
    send_target(16'sd0, 16'sd32767);
    send_target(16'sd32767, -16'sd32768);
    random_targets(70);
    drain();

    // Shortest links.
    write_length(tlik_pkg::CFG_UPPER, 15'd1);
    write_length(tlik_pkg::CFG_LOWER, 15'd1);
    send_target(16'sd2, 16'sd0);
    send_target(16'sd0, -16'sd1);
    send_target(-16'sd1, 16'sd1);
    random_targets(60);
    drain();

    // Longest links.
    write_length(tlik_pkg::CFG_UPPER, 15'd32767);
    write_length(tlik_pkg::CFG_LOWER, 15'd32767);
    send_target(-16'sd32768, -16'sd32768);
    send_target(16'sd1, 16'sd0);
    random_targets(80);
    drain();

    // Very unequal links, a thin ring of reach.
    write_length(tlik_pkg::CFG_UPPER, 15'd32767);
    write_length(tlik_pkg::CFG_LOWER, 15'd1);
    send_target(16'sd32767, 16'sd0);
    send_target(16'sd0, -16'sd32767);
    send_target(-16'sd32766, 16'sd0);
    random_targets(40);
    drain();

    // Random link settings.
    repeat (3) begin
      la = 15'($urandom_range(1, 32767));
      lb = 15'($urandom_range(1, 32767));
      if ($urandom_range(0, 1)) begin
        la = 15'($urandom_range(1, 2000));
        lb = 15'($urandom_range(1, 2000));
      end
      write_length(tlik_pkg::CFG_LOWER, lb);
      write_length(tlik_pkg::CFG_UPPER, la);
      random_targets(60);
      drain();
    end

    $display("Sent %0d targets, checked %0d results (%0d unreachable) over 7 link",
             n_sent, sb.n_checked, sb.n_unreach);
    $display("settings, with random gaps, output stalls and one long output hold-off.");
    if (sb.n_errors == 0 && sb.angles_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
